### design/axis_swap_address_generator_core_macros.svh
// Assertion macros shared by the address generator.
`ifndef AXIS_SWAP_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define AXIS_SWAP_ADDRESS_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASAG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address generator check failed");

`endif

### design/asag_pkg.sv
package asag_pkg;

    // Offset arithmetic wraps at this many bits.
    localparam int INDEX_BITS = 24;
    localparam int EXT_W      = 24;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd4;

    typedef logic [INDEX_BITS-1:0] offset_t;
    typedef logic [EXT_W-1:0]      extent_t;

    typedef struct packed {
        extent_t outer;
        extent_t first;
        extent_t middle;
        extent_t second;
        extent_t inner;
    } ext_set_t;

    typedef struct packed {
        extent_t outer;
        extent_t second;
        extent_t middle;
        extent_t first;
    } pos_set_t;

    // Products of extents used as strides; the inner stride is the row length itself.
    typedef struct packed {
        offset_t si;
        offset_t msi;
        offset_t fi;
        offset_t mfi;
        offset_t fmsi;
    } stride_set_t;

    // Which register a product from the stride unit lands in.
    typedef enum logic [3:0] {
        TGT_SI,
        TGT_MSI,
        TGT_FI,
        TGT_MFI,
        TGT_FMSI,
        TGT_OFF_O,
        TGT_SRC_F,
        TGT_DST_F,
        TGT_SRC_M,
        TGT_DST_M,
        TGT_SRC_S,
        TGT_DST_S
    } load_tgt_t;

    typedef struct packed {
        logic      valid;
        load_tgt_t tgt;
        offset_t   value;
    } load_t;

    // A zero extent behaves as one.
    function automatic extent_t ext_eff(input extent_t e);
        return (e == '0) ? EXT_W'(1) : e;
    endfunction

    // True when a counter at pos is at or past its final value.
    function automatic logic at_final(input extent_t pos, input extent_t e);
        return ({1'b0, pos} + (EXT_W + 1)'(1)) >= {1'b0, e};
    endfunction

endpackage

### design/asag_stride_calc.sv
module asag_stride_calc
    import asag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ext_set_t    ext,
    input  pos_set_t    pos,
    input  stride_set_t stride,
    output logic        busy,
    output load_t       load
);

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_SI,
        SQ_MSI,
        SQ_FI,
        SQ_MFI,
        SQ_FMSI,
        SQ_OFF_O,
        SQ_SRC_F,
        SQ_DST_F,
        SQ_SRC_M,
        SQ_DST_M,
        SQ_SRC_S,
        SQ_DST_S
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;
    offset_t    op_a;
    offset_t    op_b;
    load_tgt_t  tgt;

    // Step through the strides first, then the position partial sums that use them.
    always_comb
    begin
        state_next = state_reg;
        op_a       = '0;
        op_b       = '0;
        tgt        = TGT_SI;
        unique case (state_reg)
            SQ_IDLE:
            begin
                state_next = SQ_IDLE;
            end
            SQ_SI:
            begin
                op_a = INDEX_BITS'(ext.second);
                op_b = INDEX_BITS'(ext.inner);
                tgt  = TGT_SI;
                state_next = SQ_MSI;
            end
            SQ_MSI:
            begin
                op_a = INDEX_BITS'(ext.middle);
                op_b = stride.si;
                tgt  = TGT_MSI;
                state_next = SQ_FI;
            end
            SQ_FI:
            begin
                op_a = INDEX_BITS'(ext.first);
                op_b = INDEX_BITS'(ext.inner);
                tgt  = TGT_FI;
                state_next = SQ_MFI;
            end
            SQ_MFI:
            begin
                op_a = INDEX_BITS'(ext.middle);
                op_b = stride.fi;
                tgt  = TGT_MFI;
                state_next = SQ_FMSI;
            end
            SQ_FMSI:
            begin
                op_a = INDEX_BITS'(ext.first);
                op_b = stride.msi;
                tgt  = TGT_FMSI;
                state_next = SQ_OFF_O;
            end
            SQ_OFF_O:
            begin
                op_a = INDEX_BITS'(pos.outer);
                op_b = stride.fmsi;
                tgt  = TGT_OFF_O;
                state_next = SQ_SRC_F;
            end
            SQ_SRC_F:
            begin
                op_a = INDEX_BITS'(pos.first);
                op_b = stride.msi;
                tgt  = TGT_SRC_F;
                state_next = SQ_DST_F;
            end
            SQ_DST_F:
            begin
                op_a = INDEX_BITS'(pos.first);
                op_b = INDEX_BITS'(ext.inner);
                tgt  = TGT_DST_F;
                state_next = SQ_SRC_M;
            end
            SQ_SRC_M:
            begin
                op_a = INDEX_BITS'(pos.middle);
                op_b = stride.si;
                tgt  = TGT_SRC_M;
                state_next = SQ_DST_M;
            end
            SQ_DST_M:
            begin
                op_a = INDEX_BITS'(pos.middle);
                op_b = stride.fi;
                tgt  = TGT_DST_M;
                state_next = SQ_SRC_S;
            end
            SQ_SRC_S:
            begin
                op_a = INDEX_BITS'(pos.second);
                op_b = INDEX_BITS'(ext.inner);
                tgt  = TGT_SRC_S;
                state_next = SQ_DST_S;
            end
            SQ_DST_S:
            begin
                op_a = INDEX_BITS'(pos.second);
                op_b = stride.mfi;
                tgt  = TGT_DST_S;
                state_next = SQ_IDLE;
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = SQ_SI;
        end
    end

    // Sequencer state; any register write begins the sequence again.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Low half of one shared multiplier; the destination register follows it.
    assign load.valid = (state_reg != SQ_IDLE);
    assign load.tgt   = tgt;
    assign load.value = op_a * op_b;
    assign busy       = (state_reg != SQ_IDLE);

endmodule

### design/axis_swap_address_generator_core.sv
// A result beat is valid in the cycle after its request beat is accepted.
// Throughput: one row address pair per cycle when not stalled; a request enters as the
// pending result drains. After every configuration write the input stalls while one
// shared multiplier rebuilds the strides and the partial offsets, one product a cycle.
// Reset: extents read as 1, all position counters and offsets clear, no result pending.
`include "axis_swap_address_generator_core_macros.svh"

module axis_swap_address_generator_core
    import asag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_W-1:0]     source_offset,
    output logic [OUT_W-1:0]     dest_offset,
    output logic                 last_row
);

    ext_set_t    ext_reg;
    ext_set_t    ext_e;
    pos_set_t    pos_reg;
    pos_set_t    pos_next;
    pos_set_t    pos_cur;
    stride_set_t stride_reg;
    offset_t     ei;

    // Partial offsets: each is a position times its stride.
    offset_t     off_o_reg, src_f_reg, dst_f_reg, src_m_reg, dst_m_reg, src_s_reg, dst_s_reg;
    offset_t     off_o_next, src_f_next, dst_f_next, src_m_next, dst_m_next;
    offset_t     src_s_next, dst_s_next;
    offset_t     off_o_cur, src_f_cur, dst_f_cur, src_m_cur, dst_m_cur, src_s_cur, dst_s_cur;

    offset_t     src_sum;
    offset_t     dst_sum;
    logic        c_f, c_m, c_s, c_o;
    logic        last_now;
    logic        in_accept;
    logic        out_accept;
    logic        recalc_busy;
    load_t       load;

    logic        out_valid_reg;
    logic [OUT_W-1:0] src_out_reg;
    logic [OUT_W-1:0] dst_out_reg;
    logic        last_out_reg;

    // Effective extents and the row-length stride.
    always_comb
    begin
        ext_e.outer  = ext_eff(ext_reg.outer);
        ext_e.first  = ext_eff(ext_reg.first);
        ext_e.middle = ext_eff(ext_reg.middle);
        ext_e.second = ext_eff(ext_reg.second);
        ext_e.inner  = ext_eff(ext_reg.inner);
    end
    assign ei = INDEX_BITS'(ext_e.inner);

    asag_stride_calc u_stride_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_write),
        .ext    (ext_e),
        .pos    (pos_reg),
        .stride (stride_reg),
        .busy   (recalc_busy),
        .load   (load)
    );

    // Handshake: the output register frees itself in the same cycle it drains.
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = recalc_busy || (out_valid_reg && out_stall);
    assign in_accept  = in_valid && !in_stall;

    // A restart beat sees every counter and partial offset at zero.
    always_comb
    begin
        pos_cur   = restart ? '0 : pos_reg;
        off_o_cur = restart ? '0 : off_o_reg;
        src_f_cur = restart ? '0 : src_f_reg;
        dst_f_cur = restart ? '0 : dst_f_reg;
        src_m_cur = restart ? '0 : src_m_reg;
        dst_m_cur = restart ? '0 : dst_m_reg;
        src_s_cur = restart ? '0 : src_s_reg;
        dst_s_cur = restart ? '0 : dst_s_reg;
    end

    // Row offsets and the final-row mark.
    assign src_sum  = off_o_cur + src_f_cur + src_m_cur + src_s_cur;
    assign dst_sum  = off_o_cur + dst_f_cur + dst_m_cur + dst_s_cur;
    assign c_f      = at_final(pos_cur.first, ext_e.first);
    assign c_m      = at_final(pos_cur.middle, ext_e.middle);
    assign c_s      = at_final(pos_cur.second, ext_e.second);
    assign c_o      = at_final(pos_cur.outer, ext_e.outer);
    assign last_now = c_f && c_m && c_s && c_o;

    // Counter advance, first fastest; partials step by their stride or clear on carry.
    always_comb
    begin
        pos_next   = pos_cur;
        off_o_next = off_o_cur;
        src_f_next = src_f_cur;
        dst_f_next = dst_f_cur;
        src_m_next = src_m_cur;
        dst_m_next = dst_m_cur;
        src_s_next = src_s_cur;
        dst_s_next = dst_s_cur;
        if (c_f)
        begin
            pos_next.first = '0;
            src_f_next     = '0;
            dst_f_next     = '0;
            if (c_m)
            begin
                pos_next.middle = '0;
                src_m_next      = '0;
                dst_m_next      = '0;
                if (c_s)
                begin
                    pos_next.second = '0;
                    src_s_next      = '0;
                    dst_s_next      = '0;
                    if (c_o)
                    begin
                        pos_next.outer = '0;
                        off_o_next     = '0;
                    end
                    else
                    begin
                        pos_next.outer = pos_cur.outer + EXT_W'(1);
                        off_o_next     = off_o_cur + stride_reg.fmsi;
                    end
                end
                else
                begin
                    pos_next.second = pos_cur.second + EXT_W'(1);
                    src_s_next      = src_s_cur + ei;
                    dst_s_next      = dst_s_cur + stride_reg.mfi;
                end
            end
            else
            begin
                pos_next.middle = pos_cur.middle + EXT_W'(1);
                src_m_next      = src_m_cur + stride_reg.si;
                dst_m_next      = dst_m_cur + stride_reg.fi;
            end
        end
        else
        begin
            pos_next.first = pos_cur.first + EXT_W'(1);
            src_f_next     = src_f_cur + stride_reg.msi;
            dst_f_next     = dst_f_cur + ei;
        end
    end

    // Extent registers, counters, strides and partial offsets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg.outer   <= EXT_W'(1);
            ext_reg.first   <= EXT_W'(1);
            ext_reg.middle  <= EXT_W'(1);
            ext_reg.second  <= EXT_W'(1);
            ext_reg.inner   <= EXT_W'(1);
            pos_reg         <= '0;
            stride_reg.si   <= INDEX_BITS'(1);
            stride_reg.msi  <= INDEX_BITS'(1);
            stride_reg.fi   <= INDEX_BITS'(1);
            stride_reg.mfi  <= INDEX_BITS'(1);
            stride_reg.fmsi <= INDEX_BITS'(1);
            off_o_reg       <= '0;
            src_f_reg       <= '0;
            dst_f_reg       <= '0;
            src_m_reg       <= '0;
            dst_m_reg       <= '0;
            src_s_reg       <= '0;
            dst_s_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_OUTER:  ext_reg.outer  <= cfg_data;
                    CFG_FIRST:  ext_reg.first  <= cfg_data;
                    CFG_MIDDLE: ext_reg.middle <= cfg_data;
                    CFG_SECOND: ext_reg.second <= cfg_data;
                    CFG_INNER:  ext_reg.inner  <= cfg_data;
                    default:    ;
                endcase
            end
            if (load.valid)
            begin
                unique case (load.tgt)
                    TGT_SI:    stride_reg.si   <= load.value;
                    TGT_MSI:   stride_reg.msi  <= load.value;
                    TGT_FI:    stride_reg.fi   <= load.value;
                    TGT_MFI:   stride_reg.mfi  <= load.value;
                    TGT_FMSI:  stride_reg.fmsi <= load.value;
                    TGT_OFF_O: off_o_reg       <= load.value;
                    TGT_SRC_F: src_f_reg       <= load.value;
                    TGT_DST_F: dst_f_reg       <= load.value;
                    TGT_SRC_M: src_m_reg       <= load.value;
                    TGT_DST_M: dst_m_reg       <= load.value;
                    TGT_SRC_S: src_s_reg       <= load.value;
                    TGT_DST_S: dst_s_reg       <= load.value;
                    default:   ;
                endcase
            end
            if (in_accept)
            begin
                pos_reg   <= pos_next;
                off_o_reg <= off_o_next;
                src_f_reg <= src_f_next;
                dst_f_reg <= dst_f_next;
                src_m_reg <= src_m_next;
                dst_m_reg <= dst_m_next;
                src_s_reg <= src_s_next;
                dst_s_reg <= dst_s_next;
            end
        end
    end

    // Output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            src_out_reg  <= OUT_W'(src_sum);
            dst_out_reg  <= OUT_W'(dst_sum);
            last_out_reg <= last_now;
        end
    end

    assign out_valid     = out_valid_reg;
    assign source_offset = src_out_reg;
    assign dest_offset   = dst_out_reg;
    assign last_row      = last_out_reg;

    // A register write holds off requests while the strides are rebuilt.
    `ASAG_ASSERT_NEXT(a_cfg_stalls, clk, rst_n, cfg_write, in_stall)
    // A restart beat gives the first row at offset zero on both sides.
    `ASAG_ASSERT_NEXT(a_restart_zero, clk, rst_n, in_accept && restart,
        out_valid && (source_offset == '0) && (dest_offset == '0))
    // After the final row every counter and partial offset is back at zero.
    `ASAG_ASSERT_NEXT(a_last_wraps, clk, rst_n, in_accept && last_now,
        (pos_reg == '0) && (off_o_reg == '0) && (src_f_reg == '0) && (dst_s_reg == '0))

endmodule
